// ===== src/sacl_pkg.sv =====
package sacl_pkg;

    // Default sizes of the tag store.
    localparam int MAX_SETS_DEF   = 64;
    localparam int MAX_WAYS_DEF   = 4;
    localparam int ADDR_WIDTH_DEF = 32;

    // Fixed field widths of the ports.
    localparam int ADDR_IN_W   = 32;
    localparam int STAMP_W     = 32;
    localparam int WAY_OUT_W   = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 5;

    // Largest block offset honored by the address split.
    localparam int OFFSET_BITS_MAX = 16;

    // Result bit positions within the master-side tdata.
    localparam int OUT_HIT_BIT = 0;
    localparam int OUT_WAY_LSB = 1;
    localparam int OUT_MEM_BIT = 3;
    localparam int OUT_WB_BIT  = 4;

    // Register values after reset.
    localparam logic [4:0] OFFSET_BITS_RST     = 5'd4;
    localparam logic [2:0] INDEX_BITS_RST      = 3'd6;
    localparam logic [2:0] WAYS_IN_USE_RST     = 3'd4;
    localparam logic       WRITE_BACK_MODE_RST = 1'b0;

    // Access kinds carried in the slave-side tuser.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_OFFSET_BITS,
        CFG_INDEX_BITS,
        CFG_WAYS_IN_USE,
        CFG_WRITE_BACK_MODE
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_UPDATE
    } t_state;

endpackage

// ===== src/set_assoc_cache_lru_lookup.sv =====
// Set-associative cache tag controller with least-recently-used replacement.
// Each slave-side beat is one access (tuser: read or write, tdata: byte address);
// each one produces exactly one master-side beat with hit, way used, memory
// access and dirty writeback flags. The ways of the addressed set are visited
// one at a time through a single tag/stamp memory read port and one shared tag
// compare and age compare unit, each way read and then compared, up to and
// including the hitting way, otherwise all ways in use. The block takes no new
// access while one is in flight; a finished result sits in an output register,
// and the next access may be accepted while it waits, but its final update step
// then holds until that register is free. The valid bits clear at reset; tags,
// stamps and dirty bits live in memories that are only consulted for valid
// lines, so no clearing pass is needed. Configuration writes are expected only
// while the block is idle.
module set_assoc_cache_lru_lookup #(
    parameter int MAX_SETS   = sacl_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = sacl_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] access_addr
    input  logic [sacl_pkg::ADDR_IN_W-1:0]       s_axis_tdata,
    // [0] command
    input  logic [0:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] hit, [2:1] way_used, [3] memory_access, [4] writeback, [7:5] zero
    output logic [sacl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_wr_en,
    input  logic [sacl_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W  = WAY_W + 1;
    localparam int LINES  = MAX_SETS * MAX_WAYS;
    localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int SH_W   = 6;

    // Configuration registers.
    logic [4:0] r_offset_bits;
    logic [2:0] r_index_bits;
    logic [2:0] r_ways_in_use;
    logic       r_write_back_mode;

    // Sequencer and status.
    sacl_pkg::t_state r_state, n_state;
    logic [LINES-1:0]              r_valid;
    logic [sacl_pkg::STAMP_W-1:0]  r_stamp;
    logic                          r_m_valid;

    // Per-access working registers.
    logic                          r_is_read;
    logic [SET_W-1:0]              r_set;
    logic [ADDR_WIDTH-1:0]         r_tag;
    logic [WAY_W-1:0]              r_way;
    logic                          r_hit;
    logic                          r_inv_found;
    logic [WAY_W-1:0]              r_inv_way;
    logic [WAY_W-1:0]              r_best_way;
    logic [sacl_pkg::STAMP_W-1:0]  r_best_age;
    logic                          r_best_dirty;
    logic [ADDR_WIDTH-1:0]         r_tag_q;
    logic [sacl_pkg::STAMP_W-1:0]  r_use_q;
    logic                          r_dirty_q;
    logic [sacl_pkg::OUT_TDATA_W-1:0] r_m_data;

    // Tag, last-use and dirty memories, one line per way of each set.
    logic [ADDR_WIDTH-1:0]         tag_mem [LINES];
    logic [sacl_pkg::STAMP_W-1:0]  use_mem [LINES];
    logic                          dirty_mem [LINES];

    logic                          accept;
    logic                          rd_en;
    logic                          chk_en;
    logic                          upd_go;

    logic [4:0]                    ob_eff;
    logic [2:0]                    ib_eff;
    logic [2:0]                    ways_raw;
    logic [CNT_W-1:0]              ways_eff;
    logic [ADDR_WIDTH-1:0]         addr;
    logic [ADDR_WIDTH-1:0]         addr_sh;
    logic [SET_W-1:0]              set_mask;
    logic [SET_W-1:0]              set_in;
    logic [ADDR_WIDTH-1:0]         tag_in;

    logic [LINE_W-1:0]             set_base;
    logic [LINE_W-1:0]             cur_line;
    logic                          cur_valid;
    logic                          tag_match;
    logic [sacl_pkg::STAMP_W-1:0]  age;
    logic                          older;
    logic                          last_way;

    logic                          no_alloc;
    logic [WAY_W-1:0]              way_sel;
    logic [LINE_W-1:0]             upd_line;
    logic                          fill;
    logic                          res_mem;
    logic                          res_wb;
    logic [sacl_pkg::OUT_TDATA_W-1:0] res_data;

    // Effective register values after saturation.
    always_comb begin
        ob_eff = (r_offset_bits > 5'(sacl_pkg::OFFSET_BITS_MAX))
               ? 5'(sacl_pkg::OFFSET_BITS_MAX) : r_offset_bits;
        ib_eff = ({1'b0, r_index_bits} > 4'(IB_MAX)) ? 3'(IB_MAX) : r_index_bits;
        ways_raw = (r_ways_in_use == 3'd0) ? 3'd1 : r_ways_in_use;
        ways_eff = (int'(ways_raw) > MAX_WAYS) ? CNT_W'(MAX_WAYS) : CNT_W'(ways_raw);
    end

    // Split the incoming address into set index and tag.
    always_comb begin
        addr     = ADDR_WIDTH'(s_axis_tdata);
        addr_sh  = addr >> ob_eff;
        set_mask = (SET_W'(1) << ib_eff) - SET_W'(1);
        set_in   = SET_W'(addr_sh) & set_mask;
        tag_in   = addr >> (SH_W'(ob_eff) + SH_W'(ib_eff));
    end

    // Shared compare unit: one way of the set per visit.
    always_comb begin
        set_base  = LINE_W'(r_set * MAX_WAYS);
        cur_line  = set_base + LINE_W'(r_way);
        cur_valid = r_valid[cur_line];
        tag_match = cur_valid && (r_tag_q == r_tag);
        age       = r_stamp - r_use_q;
        older     = (r_way == '0) || (age > r_best_age);
        last_way  = ({1'b0, r_way} + CNT_W'(1)) == ways_eff;
    end

    // Outcome of the access once the search is over. A victim can only be
    // dirty when every way was valid, so the oldest way's dirty bit decides.
    always_comb begin
        no_alloc = !r_hit && !r_is_read && !r_write_back_mode;
        if (r_hit) begin
            way_sel = r_way;
        end else if (no_alloc) begin
            way_sel = '0;
        end else if (r_inv_found) begin
            way_sel = r_inv_way;
        end else begin
            way_sel = r_best_way;
        end
        upd_line = set_base + LINE_W'(way_sel);
        fill     = !r_hit && !no_alloc;
        res_mem  = r_hit ? (!r_is_read && !r_write_back_mode) : 1'b1;
        res_wb   = fill && !r_inv_found && r_best_dirty;
        res_data = '0;
        res_data[sacl_pkg::OUT_HIT_BIT] = r_hit;
        res_data[sacl_pkg::OUT_WAY_LSB +: sacl_pkg::WAY_OUT_W] =
            sacl_pkg::WAY_OUT_W'(way_sel);
        res_data[sacl_pkg::OUT_MEM_BIT] = res_mem;
        res_data[sacl_pkg::OUT_WB_BIT]  = res_wb;
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and sequencer strobes.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        chk_en        = 1'b0;
        upd_go        = 1'b0;
        unique case (r_state)
            sacl_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = sacl_pkg::ST_READ;
                end
            end
            sacl_pkg::ST_READ: begin
                rd_en   = 1'b1;
                n_state = sacl_pkg::ST_CHECK;
            end
            sacl_pkg::ST_CHECK: begin
                chk_en = 1'b1;
                if (tag_match || last_way) begin
                    n_state = sacl_pkg::ST_UPDATE;
                end else begin
                    n_state = sacl_pkg::ST_READ;
                end
            end
            sacl_pkg::ST_UPDATE: begin
                if (!r_m_valid || m_axis_tready) begin
                    upd_go  = 1'b1;
                    n_state = sacl_pkg::ST_IDLE;
                end
            end
            default: n_state = sacl_pkg::ST_IDLE;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits     <= sacl_pkg::OFFSET_BITS_RST;
            r_index_bits      <= sacl_pkg::INDEX_BITS_RST;
            r_ways_in_use     <= sacl_pkg::WAYS_IN_USE_RST;
            r_write_back_mode <= sacl_pkg::WRITE_BACK_MODE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (sacl_pkg::t_cfg_reg'(i_cfg_addr))
                sacl_pkg::CFG_OFFSET_BITS:     r_offset_bits     <= i_cfg_wdata;
                sacl_pkg::CFG_INDEX_BITS:      r_index_bits      <= i_cfg_wdata[2:0];
                sacl_pkg::CFG_WAYS_IN_USE:     r_ways_in_use     <= i_cfg_wdata[2:0];
                sacl_pkg::CFG_WRITE_BACK_MODE: r_write_back_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Line valid bits, access stamp and output beat valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_stamp   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (upd_go) begin
                r_m_valid <= 1'b1;
                r_stamp   <= r_stamp + sacl_pkg::STAMP_W'(1);
                if (fill) begin
                    r_valid[upd_line] <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Working registers of the search.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_read   <= (s_axis_tuser[0] == sacl_pkg::CMD_READ);
            r_set       <= set_in;
            r_tag       <= tag_in;
            r_way       <= '0;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
        end else if (chk_en) begin
            if (tag_match) begin
                r_hit <= 1'b1;
            end else begin
                if (!cur_valid && !r_inv_found) begin
                    r_inv_found <= 1'b1;
                    r_inv_way   <= r_way;
                end
                if (older) begin
                    r_best_age   <= age;
                    r_best_way   <= r_way;
                    r_best_dirty <= r_dirty_q;
                end
                if (!last_way) begin
                    r_way <= r_way + WAY_W'(1);
                end
            end
        end
        if (upd_go) begin
            r_m_data <= res_data;
        end
    end

    // Tag, last-use and dirty memories: one read and one write port each.
    always_ff @(posedge i_clk) begin
        if (upd_go && fill) begin
            tag_mem[upd_line] <= r_tag;
        end
        if (upd_go && !no_alloc) begin
            use_mem[upd_line] <= r_stamp;
        end
        if (upd_go && (fill || (r_hit && !r_is_read && r_write_back_mode))) begin
            dirty_mem[upd_line] <= !r_is_read;
        end
        if (rd_en) begin
            r_tag_q   <= tag_mem[cur_line];
            r_use_q   <= use_mem[cur_line];
            r_dirty_q <= dirty_mem[cur_line];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== src/sacl_checker.sv =====
module sacl_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [sacl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // After taking an access the block is busy with its search.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new access taken while a search is in flight");

    // A hit never evicts a line.
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[sacl_pkg::OUT_HIT_BIT]
        |-> !m_axis_tdata[sacl_pkg::OUT_WB_BIT])
        else $error("writeback reported on a hit");

    // Every miss goes to memory.
    a_miss_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[sacl_pkg::OUT_HIT_BIT]
        |-> m_axis_tdata[sacl_pkg::OUT_MEM_BIT])
        else $error("miss without memory access");

endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_sacl_checker (.*);
